// ===== design/sha_pkg.sv =====
package sha_pkg;

    localparam int LenBits = 29;
    localparam int CntW = LenBits + 1;
    localparam logic [CntW-1:0] SizeLimit = {1'b0, {LenBits{1'b1}}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        too_long;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== design/sha_if.sv =====
interface sha_in_if;
    logic          valid;
    logic          ready;
    sha_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    logic          valid;
    logic          ready;
    sha_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sha_fifo.sv =====
module sha_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha_in_if.sink       s,
    sha_in_if.source     m
);
    import sha_pkg::*;

    t_in        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign s.ready   = (r_cnt != 2'd2);
    assign m.valid   = (r_cnt != 2'd0);
    assign m.payload = r_mem[r_rp];
    assign w_push    = s.valid && s.ready;
    assign w_pop     = m.valid && m.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= s.payload;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== design/sha_engine.sv =====
module sha_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha_in_if.sink       s,
    sha_out_if.source    m
);
    import sha_pkg::*;

    t_state        r_st, n_st;
    logic [31:0]   r_h [8];
    logic [31:0]   r_v [8];
    logic [31:0]   r_w [16];
    logic [31:0]   r_blk [16];
    logic [CntW-1:0] r_cnt;
    logic          r_ovf;
    logic [5:0]    r_rnd;
    logic          r_fin;
    logic          r_two;
    logic [1:0]    r_pad;
    logic [2:0]    r_idx;
    logic          r_ovalid;
    t_out          r_out;

    logic          w_take;
    logic [31:0]   w_wr, w_t1, w_t2, w_x, w_y;
    logic [5:0]    w_pos;
    logic [31:0]   w_pb [16];
    logic [63:0]   w_bits;

    assign s.ready   = (r_st == ST_IDLE);
    assign w_take    = s.valid && s.ready;
    assign m.valid   = r_ovalid;
    assign m.payload = r_out;

    always_comb begin
        w_x = r_w[4'(r_rnd + 6'd1)];
        w_y = r_w[4'(r_rnd + 6'd14)];
        if (r_rnd < 6'd16) begin
            w_wr = r_blk[r_rnd[3:0]];
        end else begin
            w_wr = r_w[r_rnd[3:0]] + (ror(w_x, 7) ^ ror(w_x, 18) ^ (w_x >> 3))
                 + r_w[4'(r_rnd + 6'd9)]
                 + (ror(w_y, 17) ^ ror(w_y, 19) ^ (w_y >> 10));
        end
        w_t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RK[r_rnd] + w_wr;
        w_t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign w_pos  = r_cnt[5:0];
    assign w_bits = 64'(r_cnt) << 3;

    // padding image of the buffer
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            for (int b = 0; b < 4; b++) begin
                w_pb[k][8*(3-b) +: 8] = r_blk[k][8*(3-b) +: 8];
                if (r_pad == 2'd0) begin
                    if (6'(4*k+b) == w_pos) w_pb[k][8*(3-b) +: 8] = 8'h80;
                    else if (6'(4*k+b) > w_pos) w_pb[k][8*(3-b) +: 8] = 8'h00;
                end else begin
                    w_pb[k][8*(3-b) +: 8] = 8'h00;
                end
            end
            if (k >= 14 && !(r_pad == 2'd0 && w_pos >= 6'd56)) begin
                w_pb[k] = w_bits[32*(15-k) +: 32];
            end
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_take) begin
                    if (s.payload.byte_present && r_cnt < SizeLimit
                        && r_cnt[5:0] == 6'd63) n_st = ST_ROUND;
                    else if (s.payload.end_of_message) n_st = ST_PAD;
                end
            end
            ST_ROUND: if (r_rnd == 6'd63) n_st = ST_ADD;
            ST_ADD: begin
                if (r_fin && (r_pad == 2'd0 || r_two)) n_st = ST_PAD;
                else if (r_fin) n_st = ST_EMIT;
                else n_st = ST_IDLE;
            end
            ST_PAD: n_st = r_ovf ? ST_EMIT : ST_ROUND;
            ST_EMIT: if (!r_ovalid || m.ready) begin
                if (r_idx == 3'd7 && r_ovalid) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                if (w_take && s.payload.byte_present && r_cnt < SizeLimit) begin
                    r_blk[r_cnt[5:2]][{~r_cnt[1:0], 3'd0} +: 8] <= s.payload.data_byte;
                end
                for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                r_rnd <= 6'd0;
            end
            ST_ROUND: begin
                r_w[r_rnd[3:0]] <= w_wr;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
                r_rnd  <= r_rnd + 6'd1;
            end
            ST_PAD: begin
                for (int k = 0; k < 16; k++) r_blk[k] <= w_pb[k];
                for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                r_rnd <= 6'd0;
            end
            default: ;
        endcase
        if (r_st == ST_EMIT && (!r_ovalid || m.ready)) begin
            r_out.digest_word <= r_h[r_idx];
            r_out.word_index  <= r_idx;
            r_out.last_word   <= (r_idx == 3'd7);
            r_out.too_long    <= r_ovf;
        end
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_fin    <= 1'b0;
            r_two    <= 1'b0;
            r_pad    <= 2'd0;
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
            for (int j = 0; j < 8; j++) r_h[j] <= IV[j];
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: if (w_take) begin
                    if (s.payload.byte_present) begin
                        if (r_cnt < SizeLimit) r_cnt <= r_cnt + 1'b1;
                        else r_ovf <= 1'b1;
                    end
                    r_fin <= s.payload.end_of_message;
                    r_pad <= 2'd0;
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
                end
                ST_PAD: begin
                    if (r_ovf) begin
                        for (int j = 0; j < 8; j++) r_h[j] <= IV[j];
                    end
                    r_two <= (r_pad == 2'd0) && (w_pos >= 6'd56);
                    r_pad <= r_pad + 2'd1;
                    r_idx <= 3'd0;
                end
                ST_EMIT: if (!r_ovalid || m.ready) begin
                    r_ovalid <= 1'b1;
                    r_idx    <= r_idx + 3'd1;
                    if (r_idx == 3'd7 && r_ovalid) begin
                        r_cnt    <= '0;
                        r_ovf    <= 1'b0;
                        r_fin    <= 1'b0;
                        for (int j = 0; j < 8; j++) r_h[j] <= IV[j];
                    end
                end
                default: ;
            endcase
            if (r_st != ST_EMIT && r_ovalid && m.ready) r_ovalid <= 1'b0;
        end
    end
endmodule

// ===== design/sha256_message_hasher_core.sv =====
// sha-256 over a byte stream
// input channel: one transaction carries data_byte, byte_present and
// end_of_message; an empty transaction (no byte, no end) does nothing
// output channel: after end_of_message, eight transactions carry the digest
// words, word_index 0 first, last_word on index 7, too_long on all eight
// a two-entry queue decouples the input from the hashing engine
// a byte is taken only while the engine is idle; every 64th byte starts
// the round loop (one round per cycle) and the final add
// end of message: one or two padding blocks, then the
// eight words, one per cycle when the receiver is ready
// a message over 2^29-1 bytes gives the initial vector with too_long set
// the engine holds while the receiver stalls; the queue then fills and
// input ready drops
// reset: hash state returns to the initial vector, counters clear
module sha256_message_hasher_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     i_in,
    sha_out_if.source  o_out
);
    import sha_pkg::*;

    sha_in_if w_q ();

    sha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s       (i_in),
        .m       (w_q)
    );

    sha_engine u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s       (w_q),
        .m       (o_out)
    );

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.payload.last_word == (o_out.payload.word_index == 3'd7)))
        else $error("last_word mismatch");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.payload.last_word) |=>
        (!o_out.valid || o_out.payload.word_index != 3'd0))
        else $error("word order broken");

    a_ovf_iv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.too_long && o_out.payload.word_index == 3'd0)
        |-> o_out.payload.digest_word == IV[0])
        else $error("overflow digest not iv");
endmodule
